[rtl/ordered_list_insert_delete_search_macros.svh]
// Assertion macros shared by the ordered list RTL.
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define OL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the trigger.
`define OL_ASSERT_IMP(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define OL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[rtl/ol_pkg.sv]
// Shared types and codes for the ordered list block.
package ol_pkg;

  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_INS_AT    = 3'd2;
  localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
  localparam logic [2:0] REQ_DEL_AT    = 3'd5;
  localparam logic [2:0] REQ_SEARCH    = 3'd6;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] removed;
    logic [5:0]  found;
    logic [6:0]  count;
  } res_t;

endpackage

[rtl/ol_mem.sv]
// Entry store: one write port and one read port with registered read data.
module ol_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ol_ctrl.sv]
// Request sequencer: decodes a request and walks the circular store one entry a cycle.
`include "ordered_list_insert_delete_search_macros.svh"

module ol_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [2:0]          req_type,
  input  logic signed [31:0]  item_value,
  input  logic [5:0]          position,
  output logic                res_valid,
  input  logic                res_take,
  output ol_pkg::res_t        res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [31:0]         mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [31:0]         mem_rdata
);
  import ol_pkg::*;

  localparam int SW = CW + 1;
  localparam int LW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;
  typedef enum logic [1:0] {OP_INSERT, OP_DELETE, OP_SEARCH} op_t;

  state_t        state;
  op_t           kind;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] target;
  logic [CW-1:0] left;
  logic [CW-1:0] ridx;
  logic [CW-1:0] pidx;
  logic [31:0]   value;
  logic          up;
  logic          pv;
  logic          front;
  logic          matched;
  status_t       status;
  logic [31:0]   removed;
  logic [5:0]    found;

  logic          accept;
  logic          hit;
  logic          issue;
  logic          finish;
  logic [LW-1:0] pos_ext;
  logic [LW-1:0] cnt_ext;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;

  // Logical index to physical address, relative to the head of the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(h) + SW'(k);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign pos_ext   = LW'(position);
  assign cnt_ext   = LW'(count);
  assign head_inc  = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
  assign head_dec  = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);

  assign hit    = pv && (kind == OP_SEARCH) && (mem_rdata == value);
  assign issue  = (state == S_WALK) && (left != '0) && !hit;
  assign finish = (state == S_WALK) && !pv && (left == '0);

  assign mem_re    = issue;
  assign mem_raddr = phys(head, ridx);

  // A shift beat writes the entry read in the previous cycle one place up or down;
  // the final beat of an insert writes the new value into the opened slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys(head, target);
    mem_wdata = value;
    if (pv && (kind == OP_INSERT)) begin
      mem_we    = 1'b1;
      mem_waddr = phys(head, pidx + CW'(1));
      mem_wdata = mem_rdata;
    end else if (pv && (kind == OP_DELETE) && (pidx != target)) begin
      mem_we    = 1'b1;
      mem_waddr = phys(head, pidx - CW'(1));
      mem_wdata = mem_rdata;
    end else if (finish && (kind == OP_INSERT)) begin
      mem_we    = 1'b1;
    end
  end

  assign res_valid   = (state == S_DONE);
  assign res.status  = status;
  assign res.removed = removed;
  assign res.found   = found;
  assign res.count   = 7'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      pv      <= 1'b0;
      left    <= '0;
      matched <= 1'b0;
      front   <= 1'b0;
      kind    <= OP_SEARCH;
      status  <= ST_OK;
      removed <= '0;
      found   <= '0;
      up      <= 1'b0;
      ridx    <= '0;
      pidx    <= '0;
      target  <= '0;
      value   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            status  <= ST_OK;
            removed <= '0;
            found   <= '0;
            matched <= 1'b0;
            pv      <= 1'b0;
            value   <= item_value;
            front   <= (req_type == REQ_DEL_FRONT);
            left    <= '0;
            state   <= S_WALK;
            case (req_type)
              REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
                kind <= OP_INSERT;
                up   <= 1'b0;
                ridx <= count - CW'(1);
                if (count == CW'(CAPACITY)) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else if (req_type == REQ_INS_FRONT) begin
                  head   <= head_dec;
                  target <= '0;
                end else if (req_type == REQ_INS_BACK) begin
                  target <= count;
                end else if (pos_ext > cnt_ext) begin
                  status <= ST_BADPOS;
                  state  <= S_DONE;
                end else begin
                  target <= pos_ext[CW-1:0];
                  left   <= count - pos_ext[CW-1:0];
                end
              end
              REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
                kind <= OP_DELETE;
                up   <= 1'b1;
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_DONE;
                end else if (req_type == REQ_DEL_FRONT) begin
                  target <= '0;
                  ridx   <= '0;
                  left   <= CW'(1);
                end else if (req_type == REQ_DEL_BACK) begin
                  target <= count - CW'(1);
                  ridx   <= count - CW'(1);
                  left   <= CW'(1);
                end else if (pos_ext >= cnt_ext) begin
                  status <= ST_BADPOS;
                  state  <= S_DONE;
                end else begin
                  target <= pos_ext[CW-1:0];
                  ridx   <= pos_ext[CW-1:0];
                  left   <= count - pos_ext[CW-1:0];
                end
              end
              REQ_SEARCH: begin
                kind <= OP_SEARCH;
                up   <= 1'b1;
                ridx <= '0;
                left <= count;
              end
              default: begin
                status <= ST_BADPOS;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (issue) begin
            ridx <= up ? ridx + CW'(1) : ridx - CW'(1);
            left <= left - CW'(1);
            pidx <= ridx;
            pv   <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv && (kind == OP_DELETE) && (pidx == target)) begin
            removed <= mem_rdata;
          end
          if (hit) begin
            found   <= 6'(pidx);
            matched <= 1'b1;
            left    <= '0;
          end
          if (finish) begin
            state <= S_DONE;
            case (kind)
              OP_INSERT: count <= count + CW'(1);
              OP_DELETE: begin
                count <= count - CW'(1);
                if (front) begin
                  head <= head_inc;
                end
              end
              OP_SEARCH: status <= matched ? ST_OK : ST_NOTFOUND;
              default:   status <= ST_BADPOS;
            endcase
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OL_ASSERT_ALWAYS(a_count_range, count <= CW'(CAPACITY), "entry count beyond capacity")
  `OL_ASSERT_ALWAYS(a_head_range, SW'(head) < SW'(CAPACITY), "head pointer outside the ring")
  `OL_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
  `OL_ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted request left no work")

endmodule

[rtl/ordered_list_insert_delete_search.sv]
// Top level of the ordered list: sequencer, entry store and result register.
//
// Keeps an ordered sequence of up to CAPACITY signed 32-bit values in a ring
// buffer held in one synchronous memory. Requests arrive on the req channel
// (req_type, item_value, position) and each yields exactly one beat on the
// rsp channel (status, removed_value, found_index, entry_count). A beat moves
// when valid is high and stall is low.
// A rejected request goes from acceptance straight to the result register.
// An insert at the front or back moves no entries, and a delete at the front
// or back reads only the entry it removes. An insert or delete at a position
// walks the n = count - position entries from there to the end; a search
// walks from the front until a match or the end of the store. The memory
// read port moves one entry a cycle.
// One request is in work at a time; req_stall is high from acceptance until
// its result has been placed in the output register.
// A finished result waits in the output register while the next request is
// accepted and worked on; if the receiver stalls, the following result waits
// in the sequencer until the register frees.
// Reset clears the count and head pointer; the memory contents are not
// cleared, and only entries below the count are ever read.
module ordered_list_insert_delete_search #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] item_value,
  input  logic [5:0]         position,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [2:0]         status,
  output logic signed [31:0] removed_value,
  output logic [5:0]         found_index,
  output logic [6:0]         entry_count
);
  import ol_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          res_valid;
  logic          res_take;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  ol_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .item_value (item_value),
    .position   (position),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ol_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The result register loads when it is empty or its beat leaves this cycle.
  assign res_take = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status        <= res.status;
      removed_value <= res.removed;
      found_index   <= res.found;
      entry_count   <= res.count;
    end
  end

endmodule
